[design/ile_pkg.sv]
// Shared types and constants for the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 7;
    localparam int FPOS_W = 6;

    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_INSERT_AT    = 3'd1,
        OP_REMOVE_AT    = 3'd2,
        OP_REMOVE_VALUE = 3'd3,
        OP_READ_AT      = 3'd4,
        OP_WRITE_AT     = 3'd5,
        OP_FIND         = 3'd6,
        OP_CLEAR        = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Work a probe carries down the cell chain
    typedef enum logic [2:0] {
        K_INSERT     = 3'd0,
        K_REMOVE_AT  = 3'd1,
        K_REMOVE_VAL = 3'd2,
        K_READ       = 3'd3,
        K_WRITE      = 3'd4,
        K_FIND       = 3'd5
    } t_kind;

    // word: search value, write value, or insert carry
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [VAL_W-1:0] word;
        logic [VAL_W-1:0] data;
        logic             hit;
    } t_probe;

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  data_out;
        logic              found;
        logic [FPOS_W-1:0] found_position;
        logic [LEN_W-1:0]  length;
        logic              is_empty;
    } t_result;

endpackage

[design/ile_req_if.sv]
// Request channel: operation, position and value.
`timescale 1ns / 1ps

interface ile_req_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       op;
    logic [ile_pkg::POS_W-1:0]        position;
    logic signed [ile_pkg::VAL_W-1:0] item_value;

    modport source (output valid, op, position, item_value, input ready);
    modport sink   (input valid, op, position, item_value, output ready);
endinterface

[design/ile_rsp_if.sv]
// Response channel: status, data, find result and list length.
`timescale 1ns / 1ps

interface ile_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic signed [ile_pkg::VAL_W-1:0] data_out;
    logic                             found;
    logic [ile_pkg::FPOS_W-1:0]       found_position;
    logic [ile_pkg::LEN_W-1:0]        length;
    logic                             is_empty;

    modport source (output valid, status, data_out, found, found_position, length, is_empty,
                    input ready);
    modport sink   (input valid, status, data_out, found, found_position, length, is_empty,
                    output ready);
endinterface

[design/indexed_list_engine_top.sv]
// Top level of the indexed list engine: request decode, cell chain and result register.
`timescale 1ns / 1ps

// Bounded ordered list of up to CAPACITY signed 32-bit entries, one entry per cell in a
// chain. Requests that fail a range or capacity check, and clear, are answered from the
// count alone, without entering the chain. Every other request sends a probe down the
// chain, one cell per cycle, which shifts, reads, writes or searches as it passes. One
// request is worked at a time; a new one is accepted while the previous response waits
// at the output. Entries come up undefined after reset and only the count is cleared.
module indexed_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ile_req_if.sink    i_req,
    ile_rsp_if.source  o_rsp
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W  = ile_pkg::POS_W;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEN_W  = ile_pkg::LEN_W;
    localparam int FPOS_W = ile_pkg::FPOS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PEND
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_count;
    ile_pkg::t_probe           r_launch;
    logic [IDX_W-1:0]          r_launch_pos;
    ile_pkg::t_result          r_pend;
    ile_pkg::t_result          r_out;
    logic                      r_out_valid;

    ile_pkg::t_probe           w_probe   [CAPACITY+1];
    logic [IDX_W-1:0]          w_pos     [CAPACITY+1];
    logic [IDX_W-1:0]          w_hit_idx [CAPACITY+1];
    logic [ile_pkg::VAL_W-1:0] w_word    [CAPACITY];
    logic [CAPACITY:0]         w_valid_vec;

    logic                      accept;
    ile_pkg::t_op              w_op;
    logic                      w_full;
    logic                      w_pos_gt;
    logic                      w_pos_ge;
    logic                      w_imm;
    logic                      w_clear;
    ile_pkg::t_status          w_imm_status;
    ile_pkg::t_kind            w_kind;
    logic [IDX_W-1:0]          w_lpos;
    ile_pkg::t_result          w_imm_res;
    ile_pkg::t_result          w_exit_res;
    logic [CNT_W-1:0]          w_exit_cnt;
    ile_pkg::t_probe           w_exit;

    assign accept = i_req.valid && i_req.ready;
    assign w_op   = ile_pkg::t_op'(i_req.op);
    assign w_exit = w_probe[CAPACITY];

    // Request decode and immediate answers
    always_comb begin
        w_full       = r_count == CAP_CNT;
        w_pos_gt     = CMP_W'(i_req.position) > CMP_W'(r_count);
        w_pos_ge     = CMP_W'(i_req.position) >= CMP_W'(r_count);
        w_imm        = 1'b0;
        w_clear      = 1'b0;
        w_imm_status = ile_pkg::ST_OK;
        w_kind       = ile_pkg::K_FIND;
        w_lpos       = IDX_W'(i_req.position);
        case (w_op)
            ile_pkg::OP_APPEND: begin
                w_kind = ile_pkg::K_INSERT;
                w_lpos = IDX_W'(r_count);
                if (w_full) begin
                    w_imm        = 1'b1;
                    w_imm_status = ile_pkg::ST_FULL;
                end
            end
            ile_pkg::OP_INSERT_AT: begin
                w_kind = ile_pkg::K_INSERT;
                if (w_pos_gt) begin
                    w_imm        = 1'b1;
                    w_imm_status = ile_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_imm        = 1'b1;
                    w_imm_status = ile_pkg::ST_FULL;
                end
            end
            ile_pkg::OP_REMOVE_AT, ile_pkg::OP_READ_AT, ile_pkg::OP_WRITE_AT: begin
                if (w_op == ile_pkg::OP_REMOVE_AT) begin
                    w_kind = ile_pkg::K_REMOVE_AT;
                end else if (w_op == ile_pkg::OP_READ_AT) begin
                    w_kind = ile_pkg::K_READ;
                end else begin
                    w_kind = ile_pkg::K_WRITE;
                end
                if (w_pos_ge) begin
                    w_imm        = 1'b1;
                    w_imm_status = ile_pkg::ST_RANGE;
                end
            end
            ile_pkg::OP_REMOVE_VALUE: begin
                w_kind = ile_pkg::K_REMOVE_VAL;
            end
            ile_pkg::OP_FIND: begin
                w_kind = ile_pkg::K_FIND;
            end
            default: begin
                w_imm   = 1'b1;
                w_clear = 1'b1;
            end
        endcase

        w_imm_res.status         = w_imm_status;
        w_imm_res.data_out       = '0;
        w_imm_res.found          = 1'b0;
        w_imm_res.found_position = '0;
        w_imm_res.length         = w_clear ? '0 : LEN_W'(r_count);
        w_imm_res.is_empty       = w_clear || (r_count == '0);
    end

    // Result of a probe leaving the last cell
    always_comb begin
        w_exit_cnt = r_count;
        case (w_exit.kind)
            ile_pkg::K_INSERT:     w_exit_cnt = r_count + 1'b1;
            ile_pkg::K_REMOVE_AT:  w_exit_cnt = r_count - 1'b1;
            ile_pkg::K_REMOVE_VAL: w_exit_cnt = w_exit.hit ? r_count - 1'b1 : r_count;
            default:               w_exit_cnt = r_count;
        endcase

        w_exit_res.status = ile_pkg::ST_OK;
        if ((w_exit.kind == ile_pkg::K_FIND || w_exit.kind == ile_pkg::K_REMOVE_VAL)
            && !w_exit.hit) begin
            w_exit_res.status = ile_pkg::ST_NOT_FOUND;
        end
        w_exit_res.data_out       = w_exit.data;
        w_exit_res.found          = (w_exit.kind == ile_pkg::K_FIND) && w_exit.hit;
        w_exit_res.found_position = w_exit_res.found ? FPOS_W'(w_hit_idx[CAPACITY]) : '0;
        w_exit_res.length         = LEN_W'(w_exit_cnt);
        w_exit_res.is_empty       = w_exit_cnt == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_launch.valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_launch.valid <= (r_state == S_IDLE) && accept && !w_imm;
            if (r_state == S_PEND && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (w_imm) begin
                            r_pend  <= w_imm_res;
                            r_state <= S_PEND;
                            if (w_clear) begin
                                r_count <= '0;
                            end
                        end else begin
                            r_launch.kind  <= w_kind;
                            r_launch.word  <= i_req.item_value;
                            r_launch.data  <= '0;
                            r_launch.hit   <= 1'b0;
                            r_launch_pos   <= w_lpos;
                            r_state        <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_exit.valid) begin
                        r_pend  <= w_exit_res;
                        r_count <= w_exit_cnt;
                        r_state <= S_PEND;
                    end
                end
                S_PEND: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out       <= r_pend;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = r_state == S_IDLE;

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.data_out       = r_out.data_out;
    assign o_rsp.found          = r_out.found;
    assign o_rsp.found_position = r_out.found_position;
    assign o_rsp.length         = r_out.length;
    assign o_rsp.is_empty       = r_out.is_empty;

    // Cell chain
    assign w_probe[0]   = r_launch;
    assign w_pos[0]     = r_launch_pos;
    assign w_hit_idx[0] = '0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ile_pkg::VAL_W-1:0] w_next;
        if (k == CAPACITY - 1) begin : g_last
            assign w_next = w_word[k];
        end else begin : g_mid
            assign w_next = w_word[k+1];
        end

        ile_cell #(
            .INDEX (k),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_probe     (w_probe[k]),
            .i_pos       (w_pos[k]),
            .i_hit_idx   (w_hit_idx[k]),
            .i_count     (r_count),
            .i_next_word (w_next),
            .o_probe     (w_probe[k+1]),
            .o_pos       (w_pos[k+1]),
            .o_hit_idx   (w_hit_idx[k+1]),
            .o_word      (w_word[k])
        );
    end

    for (genvar v = 0; v <= CAPACITY; v++) begin : g_valid
        assign w_valid_vec[v] = w_probe[v].valid;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("list count above capacity");

    a_one_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valid_vec))
        else $error("more than one probe in the cell chain");

    a_probe_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_valid_vec) |-> (r_state == S_RUN))
        else $error("probe in chain outside run state");

    a_chain_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch.valid |-> ##CAPACITY w_exit.valid)
        else $error("probe did not leave the chain on time");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ($past(w_exit.valid) || $past(accept && (w_op == ile_pkg::OP_CLEAR))))
        else $error("count changed without a completed item or clear");
`endif

endmodule

[design/ile_cell.sv]
// One list cell: holds one entry and acts on the probe passing through it.
`timescale 1ns / 1ps

module ile_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ile_pkg::t_probe              i_probe,
    input  logic [IDX_W-1:0]             i_pos,
    input  logic [IDX_W-1:0]             i_hit_idx,
    input  logic [CNT_W-1:0]             i_count,
    input  logic [ile_pkg::VAL_W-1:0]    i_next_word,
    output ile_pkg::t_probe              o_probe,
    output logic [IDX_W-1:0]             o_pos,
    output logic [IDX_W-1:0]             o_hit_idx,
    output logic [ile_pkg::VAL_W-1:0]    o_word
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic [ile_pkg::VAL_W-1:0] r_word;
    logic [ile_pkg::VAL_W-1:0] n_word;
    ile_pkg::t_probe           r_probe;
    ile_pkg::t_probe           n_probe;
    logic [IDX_W-1:0]          r_pos;
    logic [IDX_W-1:0]          r_hit_idx;
    logic [IDX_W-1:0]          n_hit_idx;
    logic                      live;
    logic                      first;
    logic                      at_pos;
    logic                      past_pos;

    always_comb begin
        n_word    = r_word;
        n_probe   = i_probe;
        n_hit_idx = i_hit_idx;
        live      = MY_CNT < i_count;
        first     = live && (r_word == i_probe.word) && !i_probe.hit;
        at_pos    = i_pos == MY_IDX;
        past_pos  = MY_IDX >= i_pos;
        if (i_probe.valid) begin
            case (i_probe.kind)
                ile_pkg::K_INSERT: begin
                    // take the carry, pass the old entry on
                    if (past_pos) begin
                        n_word       = i_probe.word;
                        n_probe.word = r_word;
                    end
                end
                ile_pkg::K_REMOVE_AT: begin
                    if (past_pos) begin
                        n_word = i_next_word;
                    end
                    if (at_pos) begin
                        n_probe.data = r_word;
                    end
                end
                ile_pkg::K_REMOVE_VAL: begin
                    if (first) begin
                        n_probe.hit = 1'b1;
                        n_hit_idx   = MY_IDX;
                    end
                    // the right neighbor has not been touched yet
                    if (first || i_probe.hit) begin
                        n_word = i_next_word;
                    end
                end
                ile_pkg::K_READ: begin
                    if (at_pos) begin
                        n_probe.data = r_word;
                    end
                end
                ile_pkg::K_WRITE: begin
                    if (at_pos) begin
                        n_word = i_probe.word;
                    end
                end
                ile_pkg::K_FIND: begin
                    if (first) begin
                        n_probe.hit = 1'b1;
                        n_hit_idx   = MY_IDX;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_pos     <= i_pos;
        r_hit_idx <= n_hit_idx;
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe   = r_probe;
    assign o_pos     = r_pos;
    assign o_hit_idx = r_hit_idx;
    assign o_word    = r_word;

endmodule
